// ===== rtl/core/servo_position_sweep_from_adc_defines.svh =====
// ----------------------------------------------------------------------------
// servo_position_sweep_from_adc_defines
// assertion macros shared by the servo sweep rtl
// ----------------------------------------------------------------------------
`ifndef SERVO_POSITION_SWEEP_FROM_ADC_DEFINES_SVH
`define SERVO_POSITION_SWEEP_FROM_ADC_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spsa check failed");

// next-cycle implication, checked outside reset
`define SPSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spsa check failed");

`endif

// ===== rtl/core/spsa_pkg.sv =====
// ----------------------------------------------------------------------------
// spsa_pkg
// types and constants of the servo position sweep block
// ----------------------------------------------------------------------------
package spsa_pkg;

  localparam int CNT_W       = 7;
  localparam int SAMPLE_W    = 8;
  localparam int SUM_W       = 14;
  localparam int POS_W       = 12;
  localparam int PULSE_W     = 10;
  localparam int STEP_W      = POS_W - 5;
  localparam int STEP_SHIFT  = 5;
  localparam int PULSE_SHIFT = 2;

  // sum / 7 as (sum * ceil(2^17 / 7)) >> 17, exact for sums below 2^15
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 17;
  localparam logic [RECIP_W-1:0] RECIP_DIV7 = 15'd18725;

  localparam logic [POS_W-1:0] LIMIT_RESET = 12'd2400;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                direct_mode;
  } in_word_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_width;
    logic [POS_W-1:0]   position;
    logic               sweeping_up;
  } out_word_t;

  // one finished block handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             direct_mode;
  } blk_word_t;

  typedef struct packed {
    logic      push;
    blk_word_t word;
  } blk_push_t;

endpackage

// ===== rtl/core/spsa_front.sv =====
// ----------------------------------------------------------------------------
// spsa_front
// takes samples, drops settling samples, accumulates one block sum
// ----------------------------------------------------------------------------
module spsa_front #(
  parameter int OVERSAMPLE_COUNT = 64,
  parameter int SETTLE_DISCARD   = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  spsa_pkg::in_word_t  in_word,
  input  logic                queue_full,
  output spsa_pkg::blk_push_t blk_push
);
  import spsa_pkg::*;

  localparam logic [CNT_W-1:0] BLOCK_LEN = CNT_W'(OVERSAMPLE_COUNT + SETTLE_DISCARD);
  localparam logic [CNT_W-1:0] OS_LEN    = CNT_W'(OVERSAMPLE_COUNT);

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_dec;
  logic [SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic             accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign cnt_dec  = cnt_r - 1'b1;
  assign sum_add  = sum_r + SUM_W'(in_word.sample);

  always_comb begin
    cnt_nxt                    = cnt_r;
    sum_nxt                    = sum_r;
    blk_push.push              = 1'b0;
    blk_push.word.sum          = sum_add;
    blk_push.word.direct_mode  = in_word.direct_mode;
    if (accept) begin
      if (cnt_dec >= OS_LEN) begin
        cnt_nxt = cnt_dec;
      end else if (cnt_dec != '0) begin
        cnt_nxt = cnt_dec;
        sum_nxt = sum_add;
      end else begin
        cnt_nxt       = BLOCK_LEN;
        sum_nxt       = '0;
        blk_push.push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= BLOCK_LEN;
      sum_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

// ===== rtl/core/spsa_queue.sv =====
// ----------------------------------------------------------------------------
// spsa_queue
// short queue of finished block sums between front and back
// ----------------------------------------------------------------------------
`include "servo_position_sweep_from_adc_defines.svh"

module spsa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  spsa_pkg::blk_push_t blk_push,
  output logic                full,
  output logic                q_valid,
  output spsa_pkg::blk_word_t q_word,
  input  logic                pop
);
  import spsa_pkg::*;

  blk_word_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_word  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (blk_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({blk_push.push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_push.push) begin
      mem_r[wr_ptr_r] <= blk_push.word;
    end
  end

  `SPSA_ASSERT_IMP(a_no_push_when_full, clk, rst_n, full, !blk_push.push)
  `SPSA_ASSERT_IMP(a_cnt_in_range, clk, rst_n, 1'b1, cnt_r <= QCNT_W'(QUEUE_DEPTH))
  `SPSA_ASSERT_NXT(a_pop_drains, clk, rst_n, do_pop && !blk_push.push,
                   cnt_r == $past(cnt_r) - 1'b1)

endmodule

// ===== rtl/core/spsa_back.sv =====
// ----------------------------------------------------------------------------
// spsa_back
// divides a block sum by seven and steps the servo position
// ----------------------------------------------------------------------------
`include "servo_position_sweep_from_adc_defines.svh"

module spsa_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  spsa_pkg::blk_word_t      q_word,
  output logic                     pop,
  input  logic                     cfg_valid,
  input  logic [spsa_pkg::POS_W-1:0] cfg_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output spsa_pkg::out_word_t      out_word
);
  import spsa_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;

  logic [POS_W-1:0]   limit_r;
  logic               a_valid_r, a_valid_nxt, a_direct_r;
  logic [POS_W-1:0]   a_q_r;
  logic               a_ready, b_ready, fire;
  logic [PROD_W-1:0]  prod;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_r;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               dir_r, dir_nxt;
  logic [STEP_W-1:0]  step;
  logic [POS_W:0]     up_sum;

  assign b_ready       = !out_valid_r || !out_stall;
  assign fire          = a_valid_r && b_ready;
  assign a_ready       = !a_valid_r || b_ready;
  assign pop           = q_valid && a_ready;
  assign a_valid_nxt   = a_ready ? q_valid : a_valid_r;
  assign out_valid_nxt = b_ready ? a_valid_r : out_valid_r;
  assign prod          = PROD_W'(q_word.sum) * PROD_W'(RECIP_DIV7);

  assign step   = a_q_r[POS_W-1:STEP_SHIFT];
  assign up_sum = {1'b0, pos_r} + (POS_W+1)'(step);

  always_comb begin
    pos_nxt = pos_r;
    dir_nxt = dir_r;
    if (a_direct_r) begin
      pos_nxt = a_q_r;
    end else if (dir_r) begin
      if (up_sum >= {1'b0, limit_r}) begin
        pos_nxt = limit_r;
        dir_nxt = 1'b0;
      end else begin
        pos_nxt = up_sum[POS_W-1:0];
      end
    end else begin
      if (POS_W'(step) > pos_r) begin
        pos_nxt = '0;
        dir_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r - POS_W'(step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      dir_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        pos_r <= pos_nxt;
        dir_r <= dir_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_q_r      <= prod[RECIP_SHIFT +: POS_W];
      a_direct_r <= q_word.direct_mode;
    end
    if (fire) begin
      out_r.pulse_width <= pos_nxt[POS_W-1:PULSE_SHIFT];
      out_r.position    <= pos_nxt;
      out_r.sweeping_up <= dir_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  `SPSA_ASSERT_NXT(a_turn_down_at_limit, clk, rst_n,
                   fire && !a_direct_r && dir_r && !dir_nxt,
                   out_r.position == $past(limit_r))
  `SPSA_ASSERT_NXT(a_turn_up_at_zero, clk, rst_n,
                   fire && !a_direct_r && !dir_r && dir_nxt,
                   out_r.position == '0)
  `SPSA_ASSERT_NXT(a_out_held, clk, rst_n, out_valid_r && out_stall,
                   out_valid_r && $stable(out_r))

endmodule

// ===== rtl/core/servo_position_sweep_from_adc.sv =====
// ----------------------------------------------------------------------------
// servo_position_sweep_from_adc
// servo position from oversampled converter words, direct or sweeping
// ----------------------------------------------------------------------------
// in_word carries one converter sample and the mode bit; a word is taken at
// a clock edge with in_valid high and in_stall low. each block of
// SETTLE_DISCARD + OVERSAMPLE_COUNT words gives one out_word: pulse width,
// position and the sweep direction for the next block. other words give none.
// the word that closes a block is written to the queue, then passes the divide
// stage and the position/output register before it shows on out_valid.
// one word is taken every cycle while in_stall is low; in_stall rises only
// when the two-entry block queue is full, which happens only while out_stall
// holds results back. a held out_word stays unchanged while out_stall is high.
// cfg_data writes the sweep limit whenever cfg_valid is high (cfg_ready is
// always high); write it only while no block is in flight.
// rst_n is synchronous: the limit returns to 2400, position to zero,
// direction to down, the sample count restarts and the queue empties.
// ----------------------------------------------------------------------------
module servo_position_sweep_from_adc #(
  parameter int OVERSAMPLE_COUNT = 64,
  parameter int SETTLE_DISCARD   = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  spsa_pkg::in_word_t         in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output spsa_pkg::out_word_t        out_word,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [spsa_pkg::POS_W-1:0] cfg_data
);
  import spsa_pkg::*;

  blk_push_t blk_push;
  blk_word_t q_word;
  logic      queue_full, q_valid, pop;

  assign cfg_ready = 1'b1;

  spsa_front #(
    .OVERSAMPLE_COUNT (OVERSAMPLE_COUNT),
    .SETTLE_DISCARD   (SETTLE_DISCARD)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .queue_full (queue_full),
    .blk_push   (blk_push)
  );

  spsa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .blk_push (blk_push),
    .full     (queue_full),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .pop      (pop)
  );

  spsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
